// ===== hdl/stbs_pkg.sv =====
`default_nettype none

package stbs_pkg;

  // Table geometry.
  localparam int unsigned Depth = 1024;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = AddrW + 1;

  // Fixed result field widths.
  localparam int unsigned ModeW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 10;
  localparam int unsigned OccW    = 11;

  typedef enum logic [ModeW-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_FIRST  = 3'd2,
    MODE_LAST   = 3'd3,
    MODE_COUNT  = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PosW-1:0]    position;
    logic [OccW-1:0]    occurrences;
  } out_item_t;

  // Access request from the sequencer to the table memory.
  typedef struct packed {
    logic                    we;
    logic                    re;
    logic [AddrW-1:0]        addr;
    logic signed [DataW-1:0] wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/stbs_table.sv =====
`default_nettype none

module stbs_table (
  input  wire logic                            clk_i,
  input  wire stbs_pkg::mem_req_t              req_i,
  output logic signed [stbs_pkg::DataW-1:0]    rd_data_o
);

  logic signed [stbs_pkg::DataW-1:0] mem [stbs_pkg::Depth];
  logic signed [stbs_pkg::DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/stbs_ctrl.sv =====
`default_nettype none

module stbs_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire stbs_pkg::in_item_t              in_data_i,
  input  wire logic                            slot_free_i,
  output logic                                 res_valid_o,
  output stbs_pkg::out_item_t                  res_o,
  output stbs_pkg::mem_req_t                   mem_req_o,
  input  wire logic signed [stbs_pkg::DataW-1:0] rd_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

  state_e                             state_q;
  stbs_pkg::mode_e                    mode_q;
  logic signed [stbs_pkg::DataW-1:0]  key_q;
  logic [stbs_pkg::CntW-1:0]          count_q;
  logic [stbs_pkg::CntW-1:0]          lo_q;
  logic [stbs_pkg::CntW-1:0]          hi_ex_q;   // one past the upper bound
  logic [stbs_pkg::AddrW-1:0]         mid_q;
  logic                               first_q;   // current pass looks for the first match
  logic                               found_q;
  logic [stbs_pkg::AddrW-1:0]         idx_q;
  logic                               f_found_q;
  logic [stbs_pkg::AddrW-1:0]         f_idx_q;
  stbs_pkg::out_item_t                res_q;
  logic                               res_valid_q;

  logic                               accept;
  logic                               full;
  logic [stbs_pkg::CntW:0]            mid_sum;
  logic [stbs_pkg::AddrW-1:0]         mid;
  logic                               range_open;
  logic signed [stbs_pkg::DataW-1:0]  in_key;

  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q >= stbs_pkg::CntW'(stbs_pkg::Depth));
  assign in_key     = stbs_pkg::DataW'(in_data_i.value);
  assign range_open = (lo_q < hi_ex_q);
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_ex_q} - (stbs_pkg::CntW+1)'(1);
  assign mid        = mid_sum[stbs_pkg::AddrW:1];

  always_comb begin
    mem_req_o.we    = accept && (in_data_i.mode == stbs_pkg::MODE_APPEND) && !full;
    mem_req_o.re    = (state_q == ST_PROBE) && range_open;
    mem_req_o.addr  = mem_req_o.re ? mid : count_q[stbs_pkg::AddrW-1:0];
    mem_req_o.wdata = in_key;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            key_q   <= in_key;
            lo_q    <= '0;
            hi_ex_q <= count_q;
            found_q <= 1'b0;
            unique case (in_data_i.mode)
              stbs_pkg::MODE_CLEAR: begin
                res_q   <= '0;
                count_q <= '0;
                state_q <= ST_DONE;
              end
              stbs_pkg::MODE_APPEND: begin
                res_q.status      <= full ? stbs_pkg::STATUS_FULL : stbs_pkg::STATUS_OK;
                res_q.position    <= '0;
                res_q.occurrences <= '0;
                if (!full) begin
                  count_q <= count_q + stbs_pkg::CntW'(1);
                end
                state_q <= ST_DONE;
              end
              stbs_pkg::MODE_FIRST, stbs_pkg::MODE_COUNT: begin
                res_q   <= '0;
                mode_q  <= stbs_pkg::mode_e'(in_data_i.mode);
                first_q <= 1'b1;
                state_q <= ST_PROBE;
              end
              stbs_pkg::MODE_LAST: begin
                res_q   <= '0;
                mode_q  <= stbs_pkg::MODE_LAST;
                first_q <= 1'b0;
                state_q <= ST_PROBE;
              end
              default: begin
                // Unused modes leave the table and its entry count alone and report all zeros.
                res_q   <= '0;
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_PROBE: begin
          if (range_open) begin
            mid_q   <= mid;
            state_q <= ST_CMP;
          end else if ((mode_q == stbs_pkg::MODE_COUNT) && first_q) begin
            // First pass of a count is over: keep it and search for the last match.
            f_found_q <= found_q;
            f_idx_q   <= idx_q;
            first_q   <= 1'b0;
            found_q   <= 1'b0;
            lo_q      <= '0;
            hi_ex_q   <= count_q;
          end else begin
            if (mode_q == stbs_pkg::MODE_COUNT) begin
              if (f_found_q && found_q) begin
                res_q.occurrences <= stbs_pkg::OccW'(stbs_pkg::CntW'(idx_q)
                                     - stbs_pkg::CntW'(f_idx_q) + stbs_pkg::CntW'(1));
              end else begin
                res_q.status <= stbs_pkg::STATUS_NOT_FOUND;
              end
            end else if (found_q) begin
              res_q.position <= stbs_pkg::PosW'(idx_q);
            end else begin
              res_q.status <= stbs_pkg::STATUS_NOT_FOUND;
            end
            state_q <= ST_DONE;
          end
        end
        ST_CMP: begin
          if (rd_data_i == key_q) begin
            found_q <= 1'b1;
            idx_q   <= mid_q;
            if (first_q) begin
              hi_ex_q <= stbs_pkg::CntW'(mid_q);
            end else begin
              lo_q <= stbs_pkg::CntW'(mid_q) + stbs_pkg::CntW'(1);
            end
          end else if (key_q < rd_data_i) begin
            hi_ex_q <= stbs_pkg::CntW'(mid_q);
          end else begin
            lo_q <= stbs_pkg::CntW'(mid_q) + stbs_pkg::CntW'(1);
          end
          state_q <= ST_PROBE;
        end
        ST_DONE: begin
          if (slot_free_i) begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/sorted_table_bound_search.sv =====
// Sorted-table bound search. Software loads up to 1024 signed 32-bit entries in
// nondecreasing order with append transfers, and then asks for the first match,
// the last match or the number of matches of a key; a clear transfer empties the
// table. Every input transfer yields exactly one result transfer. A find-first
// or find-last runs one binary search of P probes, where P is at most
// floor(log2(n)) + 1 for n loaded entries; a count runs two such searches back
// to back. Each probe passes through a probe state and a compare state, because
// the single table port returns registered read data that is then compared in
// the following cycle. The input is not ready while an item is in work, but a
// new item may be taken while the previous result still waits in the output
// register. The table contents are not cleared at reset; only the entry count
// is, so no entry is read before it has been written.
`default_nettype none

module sorted_table_bound_search (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire stbs_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output stbs_pkg::out_item_t       out_data_o
);

  stbs_pkg::mem_req_t                mem_req;
  logic signed [stbs_pkg::DataW-1:0] rd_data;
  logic                              res_valid;
  stbs_pkg::out_item_t               res;
  logic                              slot_free;
  logic                              out_valid_q;
  stbs_pkg::out_item_t               out_data_q;

  // The output slot can take a new result when it is empty or drains this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  stbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  stbs_table u_table (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Output register: holds one finished result until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/stbs_checker.sv =====
`default_nettype none

module stbs_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire stbs_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire stbs_pkg::out_item_t out_data_o
);

  // A result that is not taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  // No status code beyond table full is ever produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("undefined status code");

  // A position and a count are never reported together, and neither goes with a failure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.position != '0 || out_data_o.occurrences != '0)
      |-> out_data_o.status == stbs_pkg::STATUS_OK
          && (out_data_o.position == '0 || out_data_o.occurrences == '0))
    else $error("inconsistent result fields");

  // A search keeps the input closed in the cycle after it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o
      && (in_data_i.mode == stbs_pkg::MODE_FIRST || in_data_i.mode == stbs_pkg::MODE_LAST
          || in_data_i.mode == stbs_pkg::MODE_COUNT)
      |=> !in_ready_o)
    else $error("input reopened during a search");

endmodule

bind sorted_table_bound_search stbs_checker u_checker (.*);

`default_nettype wire
